// File: rtl/rpp_fk_pkg.sv
package rpp_fk_pkg;

    localparam int CORDIC_STAGES = 16;

    localparam int ANGLE_W = 16;
    localparam int LEN_W   = 16;
    localparam int R_W     = LEN_W + 1;
    localparam int TRIG_W  = 16;
    localparam int POS_W   = 17;
    localparam int CW      = 33;
    localparam int PROD_W  = R_W + TRIG_W;

    localparam logic signed [CW-1:0] INV_GAIN       = 33'sd652032874;
    localparam logic signed [CW-1:0] PI_SCALED      = 33'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_SCALED = 33'sd1686629713;

    localparam int ATAN_ENTRIES = 24;
    localparam logic [31:0] ATAN_TABLE [0:ATAN_ENTRIES-1] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef struct packed {
        logic                    neg;
        logic signed [R_W-1:0]   r;
        logic signed [LEN_W-1:0] dz;
    } tag_t;

endpackage

// File: rtl/rpp_fk_cordic.sv
module rpp_fk_cordic
    import rpp_fk_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW-1:0] in_z,
    input  tag_t                 in_tag,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [CW-1:0] out_x,
    output logic signed [CW-1:0] out_y,
    output tag_t                 out_tag
);

    logic                 v_reg   [CORDIC_STAGES];
    logic                 en      [CORDIC_STAGES];
    logic signed [CW-1:0] x_reg   [CORDIC_STAGES];
    logic signed [CW-1:0] y_reg   [CORDIC_STAGES];
    logic signed [CW-1:0] z_reg   [CORDIC_STAGES];
    tag_t                 tag_reg [CORDIC_STAGES];
    logic signed [CW-1:0] x_next  [CORDIC_STAGES];
    logic signed [CW-1:0] y_next  [CORDIC_STAGES];
    logic signed [CW-1:0] z_next  [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        localparam logic signed [CW-1:0] ATAN_I = $signed({1'b0, ATAN_TABLE[i]});

        logic                 v_prev;
        logic signed [CW-1:0] x_prev;
        logic signed [CW-1:0] y_prev;
        logic signed [CW-1:0] z_prev;
        tag_t                 tag_prev;

        if (i == 0) begin : g_first
            assign v_prev   = in_valid;
            assign x_prev   = INV_GAIN;
            assign y_prev   = '0;
            assign z_prev   = in_z;
            assign tag_prev = in_tag;
        end else begin : g_rest
            assign v_prev   = v_reg[i-1];
            assign x_prev   = x_reg[i-1];
            assign y_prev   = y_reg[i-1];
            assign z_prev   = z_reg[i-1];
            assign tag_prev = tag_reg[i-1];
        end

        if (i == CORDIC_STAGES - 1) begin : g_last
            assign en[i] = !v_reg[i] || out_ready;
        end else begin : g_mid
            assign en[i] = !v_reg[i] || en[i+1];
        end

        always_comb begin
            if (!z_prev[CW-1]) begin
                x_next[i] = x_prev - (y_prev >>> i);
                y_next[i] = y_prev + (x_prev >>> i);
                z_next[i] = z_prev - ATAN_I;
            end else begin
                x_next[i] = x_prev + (y_prev >>> i);
                y_next[i] = y_prev - (x_prev >>> i);
                z_next[i] = z_prev + ATAN_I;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en[i]) begin
                v_reg[i] <= v_prev;
            end
            if (en[i] && v_prev) begin
                x_reg[i]   <= x_next[i];
                y_reg[i]   <= y_next[i];
                z_reg[i]   <= z_next[i];
                tag_reg[i] <= tag_prev;
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[CORDIC_STAGES-1];
    assign out_x     = x_reg[CORDIC_STAGES-1];
    assign out_y     = y_reg[CORDIC_STAGES-1];
    assign out_tag   = tag_reg[CORDIC_STAGES-1];

endmodule

// File: rtl/rpp_forward_kinematics.sv
// An accepted word passes through the input register, the CORDIC stages and stages A, B and C.
// Throughput: one word per cycle while m_ready is high; the unrolled CORDIC stages and the two
// 17x16 multipliers each take a new word every cycle, and any bubble stage accepts under stall.
// Reset: aresetn is synchronous and active low; it clears all valid bits and sets the link
// length to zero.
module rpp_forward_kinematics
    import rpp_fk_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic signed [LEN_W-1:0]   cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [ANGLE_W-1:0] s_joint_angle,
    input  logic signed [LEN_W-1:0]   s_vertical_slide,
    input  logic signed [LEN_W-1:0]   s_horizontal_slide,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [TRIG_W-1:0]  m_cos_angle,
    output logic signed [TRIG_W-1:0]  m_sin_angle,
    output logic signed [POS_W-1:0]   m_pos_x,
    output logic signed [POS_W-1:0]   m_pos_y,
    output logic signed [LEN_W-1:0]   m_pos_z
);

    localparam logic signed [TRIG_W+1:0] TRIG_MAX = 18'sd16384;
    localparam logic signed [TRIG_W+1:0] TRIG_MIN = -18'sd16384;
    localparam logic signed [PROD_W-14:0] POS_MAX = 20'sd65535;
    localparam logic signed [PROD_W-14:0] POS_MIN = -20'sd65536;

    logic signed [LEN_W-1:0] link_length_reg;

    // Input stage: angle range reduction and radius.
    logic                 v0_reg;
    logic                 en0;
    logic signed [CW-1:0] z0_reg;
    logic signed [CW-1:0] z0_next;
    tag_t                 tag0_reg;
    tag_t                 tag0_next;
    logic signed [CW-1:0] z_full;

    logic                 cv;
    logic                 c_in_ready;
    logic                 c_out_ready;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    tag_t                 ctag;

    // Stage A: rounding, clamping and sign fix of sine and cosine.
    logic                     va_reg;
    logic                     ena;
    logic signed [TRIG_W-1:0] ca_reg;
    logic signed [TRIG_W-1:0] sa_reg;
    logic signed [TRIG_W-1:0] ca_next;
    logic signed [TRIG_W-1:0] sa_next;
    logic signed [R_W-1:0]    ra_reg;
    logic signed [LEN_W-1:0]  dza_reg;
    logic signed [CW:0]       xr;
    logic signed [CW:0]       yr;
    logic signed [TRIG_W+1:0] xs;
    logic signed [TRIG_W+1:0] ys;

    // Stage B: products.
    logic                     vb_reg;
    logic                     enb;
    logic signed [TRIG_W-1:0] cb_reg;
    logic signed [TRIG_W-1:0] sb_reg;
    logic signed [PROD_W-1:0] px_reg;
    logic signed [PROD_W-1:0] py_reg;
    logic signed [LEN_W-1:0]  dzb_reg;

    // Stage C: rounding and clamping of the positions, and the output register.
    logic                     vc_reg;
    logic                     enc;
    logic signed [TRIG_W-1:0] cc_reg;
    logic signed [TRIG_W-1:0] sc_reg;
    logic signed [POS_W-1:0]  pxc_reg;
    logic signed [POS_W-1:0]  pyc_reg;
    logic signed [POS_W-1:0]  pxc_next;
    logic signed [POS_W-1:0]  pyc_next;
    logic signed [LEN_W-1:0]  dzc_reg;
    logic signed [PROD_W:0]   pxr;
    logic signed [PROD_W:0]   pyr;
    logic signed [PROD_W-14:0] pxs;
    logic signed [PROD_W-14:0] pys;

    assign enc = !vc_reg || m_ready;
    assign enb = !vb_reg || enc;
    assign ena = !va_reg || enb;
    assign c_out_ready = ena;
    assign en0 = !v0_reg || c_in_ready;
    assign s_ready = en0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_length_reg <= '0;
        end else if (cfg_wr_en) begin
            link_length_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        z_full = $signed({s_joint_angle, 17'b0});
        z0_next = z_full;
        tag0_next.neg = 1'b0;
        if (z_full > HALF_PI_SCALED) begin
            z0_next = z_full - PI_SCALED;
            tag0_next.neg = 1'b1;
        end else if (z_full < -HALF_PI_SCALED) begin
            z0_next = z_full + PI_SCALED;
            tag0_next.neg = 1'b1;
        end
        tag0_next.r  = R_W'(link_length_reg) + R_W'(s_horizontal_slide);
        tag0_next.dz = s_vertical_slide;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en0) begin
            v0_reg <= s_valid;
        end
        if (en0 && s_valid) begin
            z0_reg   <= z0_next;
            tag0_reg <= tag0_next;
        end
    end

    rpp_fk_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v0_reg),
        .in_ready  (c_in_ready),
        .in_z      (z0_reg),
        .in_tag    (tag0_reg),
        .out_valid (cv),
        .out_ready (c_out_ready),
        .out_x     (cx),
        .out_y     (cy),
        .out_tag   (ctag)
    );

    always_comb begin
        xr = (CW+1)'(cx) + (CW+1)'(32768);
        yr = (CW+1)'(cy) + (CW+1)'(32768);
        xs = xr[CW:16];
        ys = yr[CW:16];
        if (xs > TRIG_MAX) begin
            ca_next = TRIG_W'(TRIG_MAX);
        end else if (xs < TRIG_MIN) begin
            ca_next = TRIG_W'(TRIG_MIN);
        end else begin
            ca_next = xs[TRIG_W-1:0];
        end
        if (ys > TRIG_MAX) begin
            sa_next = TRIG_W'(TRIG_MAX);
        end else if (ys < TRIG_MIN) begin
            sa_next = TRIG_W'(TRIG_MIN);
        end else begin
            sa_next = ys[TRIG_W-1:0];
        end
        if (ctag.neg) begin
            ca_next = -ca_next;
            sa_next = -sa_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (ena) begin
            va_reg <= cv;
        end
        if (ena && cv) begin
            ca_reg  <= ca_next;
            sa_reg  <= sa_next;
            ra_reg  <= ctag.r;
            dza_reg <= ctag.dz;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (enb) begin
            vb_reg <= va_reg;
        end
        if (enb && va_reg) begin
            px_reg  <= PROD_W'(ra_reg) * PROD_W'(ca_reg);
            py_reg  <= PROD_W'(ra_reg) * PROD_W'(sa_reg);
            cb_reg  <= ca_reg;
            sb_reg  <= sa_reg;
            dzb_reg <= dza_reg;
        end
    end

    always_comb begin
        pxr = (PROD_W+1)'(px_reg) + (PROD_W+1)'(8192);
        pyr = (PROD_W+1)'(py_reg) + (PROD_W+1)'(8192);
        pxs = pxr[PROD_W:14];
        pys = pyr[PROD_W:14];
        if (pxs > POS_MAX) begin
            pxc_next = POS_W'(POS_MAX);
        end else if (pxs < POS_MIN) begin
            pxc_next = POS_W'(POS_MIN);
        end else begin
            pxc_next = pxs[POS_W-1:0];
        end
        if (pys > POS_MAX) begin
            pyc_next = POS_W'(POS_MAX);
        end else if (pys < POS_MIN) begin
            pyc_next = POS_W'(POS_MIN);
        end else begin
            pyc_next = pys[POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (enc) begin
            vc_reg <= vb_reg;
        end
        if (enc && vb_reg) begin
            cc_reg  <= cb_reg;
            sc_reg  <= sb_reg;
            pxc_reg <= pxc_next;
            pyc_reg <= pyc_next;
            dzc_reg <= dzb_reg;
        end
    end

    assign m_valid     = vc_reg;
    assign m_cos_angle = cc_reg;
    assign m_sin_angle = sc_reg;
    assign m_pos_x     = pxc_reg;
    assign m_pos_y     = pyc_reg;
    assign m_pos_z     = dzc_reg;

endmodule

// File: bench/tb_top.sv
module tb_top
    import rpp_fk_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 50;
    localparam longint START_X = 64'sd652032874;
    localparam longint PI_Q30 = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam int ARCTAN_COUNT = 24;

    typedef struct {
        logic signed [TRIG_W-1:0] cos_angle;
        logic signed [TRIG_W-1:0] sin_angle;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [LEN_W-1:0]  pos_z;
    } pose_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic signed [LEN_W-1:0]   cfg_wr_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [ANGLE_W-1:0] s_joint_angle = '0;
    logic signed [LEN_W-1:0]   s_vertical_slide = '0;
    logic signed [LEN_W-1:0]   s_horizontal_slide = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [TRIG_W-1:0]  m_cos_angle;
    logic signed [TRIG_W-1:0]  m_sin_angle;
    logic signed [POS_W-1:0]   m_pos_x;
    logic signed [POS_W-1:0]   m_pos_y;
    logic signed [LEN_W-1:0]   m_pos_z;

    longint arctan_q30 [0:ARCTAN_COUNT-1] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
        64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
        64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    pose_t                   expected_poses [$];
    logic signed [LEN_W-1:0] link_setting = '0;
    bit                      steady = 1'b0;
    int                      mismatch_count = 0;
    int                      result_count = 0;
    int                      cycle_count = 0;

    rpp_forward_kinematics dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_joint_angle     (s_joint_angle),
        .s_vertical_slide  (s_vertical_slide),
        .s_horizontal_slide(s_horizontal_slide),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cos_angle       (m_cos_angle),
        .m_sin_angle       (m_sin_angle),
        .m_pos_x           (m_pos_x),
        .m_pos_y           (m_pos_y),
        .m_pos_z           (m_pos_z)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic pose_t predict_pose(input logic signed [ANGLE_W-1:0] angle,
                                           input logic signed [LEN_W-1:0] vslide,
                                           input logic signed [LEN_W-1:0] hslide,
                                           input logic signed [LEN_W-1:0] link);
        pose_t  p;
        longint z;
        longint x;
        longint y;
        longint nx;
        longint c;
        longint s;
        longint r;
        bit     flip;
        z = longint'(angle) * 131072;
        x = START_X;
        y = 0;
        flip = 1'b0;
        if (z > HALF_PI_Q30) begin
            z = z - PI_Q30;
            flip = 1'b1;
        end else if (z < -HALF_PI_Q30) begin
            z = z + PI_Q30;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STAGES && i < ARCTAN_COUNT; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - arctan_q30[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + arctan_q30[i];
            end
            x = nx;
        end
        c = clip((x + 32768) >>> 16, -16384, 16384);
        s = clip((y + 32768) >>> 16, -16384, 16384);
        if (flip) begin
            c = -c;
            s = -s;
        end
        r = longint'(link) + longint'(hslide);
        p.cos_angle = c[TRIG_W-1:0];
        p.sin_angle = s[TRIG_W-1:0];
        p.pos_x = POS_W'(clip((r * c + 8192) >>> 14, -65536, 65535));
        p.pos_y = POS_W'(clip((r * s + 8192) >>> 14, -65536, 65535));
        p.pos_z = vslide;
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic signed [POS_W-1:0] got,
                               input logic signed [POS_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("word %0d: %s is %0d, expected %0d",
                                      result_count, name, got, want));
    endtask

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 25);
    end

    always @(posedge aclk) begin : check_results
        pose_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_poses.size() == 0) begin
                report_mismatch($sformatf("word %0d arrived with no pose pending", result_count));
            end else begin
                want = expected_poses.pop_front();
                check_field("cos_angle", m_cos_angle, want.cos_angle);
                check_field("sin_angle", m_sin_angle, want.sin_angle);
                check_field("pos_x", m_pos_x, want.pos_x);
                check_field("pos_y", m_pos_y, want.pos_y);
                check_field("pos_z", m_pos_z, want.pos_z);
            end
            result_count++;
        end
    end

    task automatic send_pose(input logic signed [ANGLE_W-1:0] angle,
                             input logic signed [LEN_W-1:0] vslide,
                             input logic signed [LEN_W-1:0] hslide);
        while (!steady && $urandom_range(0, 99) < 25) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_joint_angle <= angle;
        s_vertical_slide <= vslide;
        s_horizontal_slide <= hslide;
        do
            @(posedge aclk);
        while (!s_ready);
        expected_poses.push_back(predict_pose(angle, vslide, hslide, link_setting));
    endtask

    task automatic drain_poses();
        s_valid <= 1'b0;
        while (expected_poses.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_link_length(input logic signed [LEN_W-1:0] value);
        drain_poses();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        link_setting = value;
    endtask

    function automatic logic signed [LEN_W-1:0] random_slide();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return LEN_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic signed [ANGLE_W-1:0] random_angle();
        int near;
        near = int'($urandom_range(0, 8)) - 4;
        case ($urandom_range(0, 9))
            0: return ANGLE_W'($urandom_range(0, 65535));
            1: return ANGLE_W'(($urandom_range(0, 1) ? 12868 : -12868) + near);
            2: return ANGLE_W'(($urandom_range(0, 1) ? 25736 : -25736) + near);
            default: return ANGLE_W'(int'($urandom_range(0, 51472)) - 25736);
        endcase
    endfunction

    // Link length still at its reset value of zero.
    task automatic test_reset_link();
        send_pose(16'sd0, 16'sd0, 16'sd0);
        send_pose(16'sd0, 16'sh7FFF, 16'sh7FFF);
        send_pose(16'sd12867, 16'sh8000, 16'sh8000);
        send_pose(16'sd12868, 16'sd256, 16'sh7FFF);
        send_pose(-16'sd12867, 16'sd0, 16'sh7FFF);
        send_pose(-16'sd12868, -16'sd256, 16'sh8000);
        send_pose(16'sd25736, 16'sd100, 16'sh7FFF);
        send_pose(-16'sd25736, 16'sd100, 16'sh8000);
        send_pose(16'sh7FFF, 16'sh5555, 16'sh2AAA);
        send_pose(16'sh8000, 16'shAAAA, 16'shD555);
        send_pose(16'sd6434, 16'sd1, 16'sd1000);
        send_pose(-16'sd1, -16'sd1, -16'sd1);
        send_pose(16'sd1, 16'sd1, 16'sd1);
        send_pose(16'sd16384, 16'sd0, -16'sd5000);
    endtask

    // Largest radius in both signs, including products that saturate.
    task automatic test_link_extremes();
        write_link_length(16'sh7FFF);
        send_pose(16'sd0, 16'sd0, 16'sh7FFF);
        send_pose(16'sd12867, 16'sd0, 16'sh7FFF);
        send_pose(16'sd25736, 16'sd0, 16'sh8000);
        write_link_length(16'sh8000);
        send_pose(16'sd0, 16'sd0, 16'sh8000);
        send_pose(16'sd25736, 16'sd0, 16'sh8000);
        send_pose(-16'sd25736, 16'sd0, 16'sh8000);
        send_pose(-16'sd12868, 16'sd0, 16'sh8000);
        send_pose(16'sd12868, 16'sd0, 16'sh8000);
    endtask

    task automatic test_random_poses();
        logic signed [LEN_W-1:0] links [0:4];
        links[0] = LEN_W'($urandom_range(0, 65535));
        links[1] = 16'sd256;
        links[2] = 16'sh8000;
        links[3] = 16'sh7FFF;
        links[4] = LEN_W'($urandom_range(0, 65535));
        for (int phase = 0; phase < 5; phase++) begin
            write_link_length(links[phase]);
            steady = (phase == 2);
            repeat (260)
                send_pose(random_angle(), random_slide(), random_slide());
            drain_poses();
            steady = 1'b0;
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_link();
        test_link_extremes();
        test_random_poses();
        drain_poses();
        repeat (CORDIC_STAGES + 8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
